// ----- sv/mapc_pkg.sv -----
package mapc_pkg;

    localparam int CODE_W      = 3;
    localparam int AGENT_OUT_W = 6;
    localparam int STEP_OUT_W  = 16;

    localparam logic [CODE_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_START  = 3'd1;
    localparam logic [CODE_W-1:0] ERR_GOAL   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_SIZE   = 3'd3;
    localparam logic [CODE_W-1:0] ERR_MOVE   = 3'd4;
    localparam logic [CODE_W-1:0] ERR_VERTEX = 3'd5;
    localparam logic [CODE_W-1:0] ERR_SWAP   = 3'd6;

    typedef struct packed {
        logic start_bad;
        logic goal_bad;
        logic eos;
        logic eop;
    } t_flags;

endpackage

// ----- sv/mapc_front.sv -----
module mapc_front
    import mapc_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_goal_x,
    input  logic [COORD_BITS-1:0] i_goal_y,
    input  logic                  i_end_of_step,
    input  logic                  i_end_of_plan,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output logic [COORD_BITS-1:0] o_q_px,
    output logic [COORD_BITS-1:0] o_q_py,
    output t_flags                o_q_flags
);

    logic [COORD_BITS-1:0] r_px [2];
    logic [COORD_BITS-1:0] r_py [2];
    t_flags                r_fl [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;
    logic                  n_push;
    logic                  n_pop;
    t_flags                n_fl;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign n_push    = i_valid && !o_stall;
    assign n_pop     = i_q_pop && o_q_valid;
    assign o_q_px    = r_px[r_rp];
    assign o_q_py    = r_py[r_rp];
    assign o_q_flags = r_fl[r_rp];

    always_comb begin
        n_fl.start_bad = (i_pos_x != i_start_x) || (i_pos_y != i_start_y);
        n_fl.goal_bad  = (i_pos_x != i_goal_x) || (i_pos_y != i_goal_y);
        n_fl.eos       = i_end_of_step || i_end_of_plan;
        n_fl.eop       = i_end_of_plan;
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_px[r_wp] <= i_pos_x;
            r_py[r_wp] <= i_pos_y;
            r_fl[r_wp] <= n_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wp <= ~r_wp;
            if (n_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(n_push) - 2'(n_pop);
        end
    end

endmodule

// ----- sv/mapc_back.sv -----
module mapc_back
    import mapc_pkg::*;
#(
    parameter int MAX_AGENTS = 64,
    parameter int COORD_BITS = 10,
    parameter int STEP_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  logic [COORD_BITS-1:0]  i_q_px,
    input  logic [COORD_BITS-1:0]  i_q_py,
    input  t_flags                 i_q_flags,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_plan_ok,
    output logic [CODE_W-1:0]      o_error_code,
    output logic [STEP_OUT_W-1:0]  o_error_step,
    output logic [AGENT_OUT_W-1:0] o_error_agent,
    output logic [AGENT_OUT_W-1:0] o_other_agent
);

    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int KW = $clog2(MAX_AGENTS + 2);
    localparam int TW = $clog2(2 * MAX_AGENTS + 1);
    localparam int CW = 2 * COORD_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RDK  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [CW-1:0] r_mem0 [MAX_AGENTS];
    logic [CW-1:0] r_mem1 [MAX_AGENTS];
    logic [CW-1:0] r_rd0;
    logic [CW-1:0] r_rd1;

    logic [1:0]            r_state;
    logic                  r_sel;
    logic [KW-1:0]         r_k;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    t_flags                r_fl;
    logic [CW-1:0]         r_pk;
    logic [AW-1:0]         r_j;
    logic [KW-1:0]         r_cnt;
    logic [KW-1:0]         r_idx;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_fe_v;
    logic [CODE_W-1:0]     r_fe_code;
    logic [STEP_BITS-1:0]  r_fe_step;
    logic [AW-1:0]         r_fe_agent;
    logic [AW-1:0]         r_fe_other;
    logic                  r_se_v;
    logic [KW-1:0]         r_se_agent;
    logic                  r_over;
    logic                  r_gbad;
    logic [KW-1:0]         r_gagent;
    logic                  r_cv;
    logic [CODE_W-1:0]     r_c_code;
    logic [AW-1:0]         r_c_agent;
    logic [AW-1:0]         r_c_other;
    logic [TW-1:0]         r_c_t;
    logic                  r_ov;
    logic                  r_o_ok;
    logic [CODE_W-1:0]     r_o_code;
    logic [STEP_OUT_W-1:0] r_o_step;
    logic [AGENT_OUT_W-1:0] r_o_agent;
    logic [AGENT_OUT_W-1:0] r_o_other;

    logic                  n_we;
    logic [AW-1:0]         n_wa;
    logic [CW-1:0]         n_wd;
    logic [AW-1:0]         n_ra;
    logic [CW-1:0]         n_cur;
    logic [CW-1:0]         n_prev;
    logic [CW-1:0]         n_cell;
    logic [COORD_BITS-1:0] n_dx;
    logic [COORD_BITS-1:0] n_dy;
    logic                  n_offer;
    logic [CODE_W-1:0]     n_of_code;
    logic [AW-1:0]         n_of_agent;
    logic [AW-1:0]         n_of_other;
    logic [TW-1:0]         n_of_t;
    logic                  n_take;
    logic [KW-1:0]         n_n;
    logic                  n_over;
    logic [KW-1:0]         n_cnt;
    logic                  n_fe_v;
    logic [CODE_W-1:0]     n_fe_code;
    logic [STEP_BITS-1:0]  n_fe_step;
    logic [AW-1:0]         n_fe_agent;
    logic [AW-1:0]         n_fe_other;
    logic                  n_space;
    logic                  n_done;
    logic                  n_cmp;
    logic                  n_o_ok;
    logic [CODE_W-1:0]     n_o_code;
    logic [STEP_OUT_W-1:0] n_o_step;
    logic [AGENT_OUT_W-1:0] n_o_agent;
    logic [AGENT_OUT_W-1:0] n_o_other;

    assign n_cur   = r_sel ? r_rd1 : r_rd0;
    assign n_prev  = r_sel ? r_rd0 : r_rd1;
    assign n_cell  = {r_py, r_px};
    assign n_space = !r_ov || !i_stall;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign n_cmp   = (r_step != '0) && !r_fe_v && (r_idx < r_cnt);
    assign n_done  = (r_state == S_FIN) && (!r_fl.eop || n_space);

    always_comb begin
        n_we = 1'b0;
        n_wa = r_k[AW-1:0];
        n_wd = n_cell;
        n_ra = AW'(r_j + 1'b1);
        case (r_state)
            S_IDLE: begin
                n_wa = r_idx[AW-1:0];
                n_wd = {i_q_py, i_q_px};
                n_we = o_q_pop && (r_step == '0) && (r_idx < KW'(MAX_AGENTS));
                n_ra = r_idx[AW-1:0];
            end
            S_RDK: begin
                n_we = 1'b1;
                n_ra = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we && !r_sel) r_mem0[n_wa] <= n_wd;
        if (n_we && r_sel) r_mem1[n_wa] <= n_wd;
        r_rd0 <= r_mem0[n_ra];
        r_rd1 <= r_mem1[n_ra];
    end

    always_comb begin
        n_dx       = (r_px > n_prev[COORD_BITS-1:0]) ? r_px - n_prev[COORD_BITS-1:0]
                                                    : n_prev[COORD_BITS-1:0] - r_px;
        n_dy       = (r_py > n_prev[CW-1:COORD_BITS]) ? r_py - n_prev[CW-1:COORD_BITS]
                                                     : n_prev[CW-1:COORD_BITS] - r_py;
        n_offer    = 1'b0;
        n_of_code  = ERR_MOVE;
        n_of_agent = r_k[AW-1:0];
        n_of_other = '0;
        n_of_t     = '0;
        case (r_state)
            S_RDK: begin
                n_offer = ({1'b0, n_dx} + {1'b0, n_dy}) > (COORD_BITS + 1)'(1);
            end
            S_CMP: begin
                n_of_agent = r_j;
                n_of_other = r_k[AW-1:0];
                if (n_cell == n_cur) begin
                    n_offer   = 1'b1;
                    n_of_code = ERR_VERTEX;
                    n_of_t    = TW'(2 * r_k + 1);
                end else if (n_cell == n_prev && r_pk == n_cur) begin
                    n_offer   = 1'b1;
                    n_of_code = ERR_SWAP;
                    n_of_t    = TW'(2 * r_k + 2);
                end
            end
            default: begin
            end
        endcase
        n_take = n_offer && (!r_cv || n_of_agent < r_c_agent
                 || (n_of_agent == r_c_agent && n_of_t < r_c_t));
    end

    always_comb begin
        n_n        = (r_k < KW'(MAX_AGENTS + 1)) ? KW'(r_k + 1'b1) : r_k;
        n_over     = r_over;
        n_cnt      = r_cnt;
        n_fe_v     = r_fe_v;
        n_fe_code  = r_fe_code;
        n_fe_step  = r_fe_step;
        n_fe_agent = r_fe_agent;
        n_fe_other = r_fe_other;
        if (r_step == '0) begin
            n_over = n_n > KW'(MAX_AGENTS);
            n_cnt  = n_over ? KW'(MAX_AGENTS) : n_n;
        end else if (!r_fe_v) begin
            if (n_n != r_cnt) begin
                n_fe_v     = 1'b1;
                n_fe_code  = ERR_SIZE;
                n_fe_step  = r_step;
                n_fe_agent = '0;
                n_fe_other = '0;
            end else if (r_cv) begin
                n_fe_v     = 1'b1;
                n_fe_code  = r_c_code;
                n_fe_step  = r_step;
                n_fe_agent = r_c_agent;
                n_fe_other = r_c_other;
            end
        end
    end

    always_comb begin
        n_o_ok    = 1'b1;
        n_o_code  = ERR_NONE;
        n_o_step  = '0;
        n_o_agent = '0;
        n_o_other = '0;
        if (n_over) begin
            n_o_ok   = 1'b0;
            n_o_code = ERR_SIZE;
        end else if (r_se_v) begin
            n_o_ok    = 1'b0;
            n_o_code  = ERR_START;
            n_o_agent = AGENT_OUT_W'(r_se_agent);
        end else if (r_gbad || n_n != n_cnt) begin
            n_o_ok    = 1'b0;
            n_o_code  = ERR_GOAL;
            n_o_step  = STEP_OUT_W'(r_step);
            n_o_agent = r_gbad ? AGENT_OUT_W'(r_gagent) : '0;
        end else if (n_fe_v) begin
            n_o_ok    = 1'b0;
            n_o_code  = n_fe_code;
            n_o_step  = STEP_OUT_W'(n_fe_step);
            n_o_agent = AGENT_OUT_W'(n_fe_agent);
            n_o_other = AGENT_OUT_W'(n_fe_other);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k  <= r_idx;
                r_px <= i_q_px;
                r_py <= i_q_py;
                r_fl <= i_q_flags;
            end
            S_RDK: r_pk <= n_prev;
            default: begin
            end
        endcase
        if (n_take) begin
            r_c_code  <= n_of_code;
            r_c_agent <= n_of_agent;
            r_c_other <= n_of_other;
            r_c_t     <= n_of_t;
        end
        if (n_done && r_fl.eop) begin
            r_o_ok    <= n_o_ok;
            r_o_code  <= n_o_code;
            r_o_step  <= n_o_step;
            r_o_agent <= n_o_agent;
            r_o_other <= n_o_other;
        end
        if (n_done && r_fl.eos) begin
            r_fe_code  <= n_fe_code;
            r_fe_step  <= n_fe_step;
            r_fe_agent <= n_fe_agent;
            r_fe_other <= n_fe_other;
        end
        if (o_q_pop && i_q_flags.start_bad && !r_se_v && r_step == '0) r_se_agent <= r_idx;
        if (o_q_pop && i_q_flags.goal_bad && !r_gbad) r_gagent <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_step  <= '0;
            r_fe_v  <= 1'b0;
            r_se_v  <= 1'b0;
            r_over  <= 1'b0;
            r_gbad  <= 1'b0;
            r_cv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (n_done && r_fl.eop) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (n_take) r_cv <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_flags.start_bad && r_step == '0) r_se_v <= 1'b1;
                        if (i_q_flags.goal_bad) r_gbad <= 1'b1;
                        r_state <= n_cmp ? S_RDK : S_FIN;
                    end
                end
                S_RDK: begin
                    r_j     <= '0;
                    r_state <= (r_k == '0) ? S_FIN : S_CMP;
                end
                S_CMP: begin
                    r_j <= AW'(r_j + 1'b1);
                    if (KW'(r_j) == KW'(r_k - 1'b1)) r_state <= S_FIN;
                end
                default: begin
                    if (n_done) begin
                        r_state <= S_IDLE;
                        r_idx   <= r_fl.eos ? '0 : n_n;
                        if (r_fl.eop) begin
                            r_cnt  <= '0;
                            r_step <= '0;
                            r_fe_v <= 1'b0;
                            r_se_v <= 1'b0;
                            r_over <= 1'b0;
                            r_gbad <= 1'b0;
                            r_cv   <= 1'b0;
                        end else if (r_fl.eos) begin
                            r_over <= n_over;
                            r_cnt  <= n_cnt;
                            r_fe_v <= n_fe_v;
                            r_sel  <= ~r_sel;
                            r_gbad <= 1'b0;
                            r_cv   <= 1'b0;
                            if (r_step != '1) r_step <= r_step + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_plan_ok     = r_o_ok;
    assign o_error_code  = r_o_code;
    assign o_error_step  = r_o_step;
    assign o_error_agent = r_o_agent;
    assign o_other_agent = r_o_other;

endmodule

// ----- sv/multi_agent_plan_checker.sv -----
// Plan checker: one beat per agent position, timesteps in order, one verdict beat on the
// last beat of the plan. A two-entry queue takes beats while the checker works. Agent k
// of a compared timestep is checked against agents 0 to k-1 of the current and previous
// rows, read one entry per cycle since each row bank has one read port. The rows live in
// two banks that swap roles at each timestep.
module multi_agent_plan_checker
    import mapc_pkg::*;
#(
    parameter int MAX_AGENTS = 64,
    parameter int COORD_BITS = 10,
    parameter int STEP_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_BITS-1:0]  i_pos_x,
    input  logic [COORD_BITS-1:0]  i_pos_y,
    input  logic [COORD_BITS-1:0]  i_start_x,
    input  logic [COORD_BITS-1:0]  i_start_y,
    input  logic [COORD_BITS-1:0]  i_goal_x,
    input  logic [COORD_BITS-1:0]  i_goal_y,
    input  logic                   i_end_of_step,
    input  logic                   i_end_of_plan,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_plan_ok,
    output logic [CODE_W-1:0]      o_error_code,
    output logic [STEP_OUT_W-1:0]  o_error_step,
    output logic [AGENT_OUT_W-1:0] o_error_agent,
    output logic [AGENT_OUT_W-1:0] o_other_agent
);

    logic                  q_valid;
    logic                  q_pop;
    logic [COORD_BITS-1:0] q_px;
    logic [COORD_BITS-1:0] q_py;
    t_flags                q_flags;

    mapc_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_goal_x     (i_goal_x),
        .i_goal_y     (i_goal_y),
        .i_end_of_step(i_end_of_step),
        .i_end_of_plan(i_end_of_plan),
        .o_q_valid    (q_valid),
        .i_q_pop      (q_pop),
        .o_q_px       (q_px),
        .o_q_py       (q_py),
        .o_q_flags    (q_flags)
    );

    mapc_back #(
        .MAX_AGENTS(MAX_AGENTS),
        .COORD_BITS(COORD_BITS),
        .STEP_BITS (STEP_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_px       (q_px),
        .i_q_py       (q_py),
        .i_q_flags    (q_flags),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_plan_ok    (o_plan_ok),
        .o_error_code (o_error_code),
        .o_error_step (o_error_step),
        .o_error_agent(o_error_agent),
        .o_other_agent(o_other_agent)
    );

endmodule

// ----- sv/mapc_checker.sv -----
module mapc_checker
    import mapc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_plan_ok,
    input logic [CODE_W-1:0]      o_error_code,
    input logic [STEP_OUT_W-1:0]  o_error_step,
    input logic [AGENT_OUT_W-1:0] o_error_agent,
    input logic [AGENT_OUT_W-1:0] o_other_agent
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_error_code))
        else $error("verdict dropped while stalled");

    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_plan_ok |-> o_error_code == ERR_NONE && o_error_step == '0
        && o_error_agent == '0 && o_other_agent == '0)
        else $error("success verdict carries error data");

    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_plan_ok |-> o_error_code != ERR_NONE && o_error_code != 3'd7)
        else $error("failure verdict without error code");

    a_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_VERTEX && o_error_code != ERR_SWAP
        |-> o_other_agent == '0)
        else $error("second agent set for non-conflict error");

    a_start_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error_code == ERR_START || o_error_code == ERR_SIZE)
        && o_error_step == '0 |-> o_error_code == ERR_SIZE || !o_plan_ok)
        else $error("start error verdict inconsistent");

endmodule

bind multi_agent_plan_checker mapc_checker u_mapc_checker (.*);
